[src/co2_sensor_frame_receiver_core_defines.svh]
// Assertion macros for the gas sensor frame receiver.
// Included by co2sfr_back, the RTL file that carries concurrent assertions.
`ifndef CO2_SENSOR_FRAME_RECEIVER_CORE_DEFINES_SVH
`define CO2_SENSOR_FRAME_RECEIVER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CO2SFR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CO2SFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CO2SFR_ASSERT(label, clk, rst, prop, msg)
`define CO2SFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[src/co2sfr_pkg.sv]
// Shared types and constants of the gas sensor frame receiver.
// Used by every module of the block; depends on nothing.
`default_nettype none

package co2sfr_pkg;

   localparam int COUNT_BITS      = 24;
   localparam int VALUE_BITS      = 16;
   localparam int TOTAL_BITS      = VALUE_BITS + COUNT_BITS;
   localparam int OUT_COUNT_BITS  = 24;
   localparam int CNT_EXT_BITS    = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;
   localparam int DIV_CNT_BITS    = $clog2(TOTAL_BITS + 1);
   localparam int FIFO_DEPTH      = 2;
   localparam int FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS   = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0]                START_BYTE    = 8'hFF;
   localparam logic [7:0]                REPLY_CODE    = 8'h86;
   localparam logic [3:0]                CHECK_POS     = 4'd8;
   localparam logic [VALUE_BITS-1:0]     MAX_PPM_RESET = 16'd5000;
   localparam logic [COUNT_BITS-1:0]     COUNT_MAX     = '1;
   localparam logic [OUT_COUNT_BITS-1:0] OUT_COUNT_MAX = '1;
   localparam logic [7:0]                FAIL_MAX      = 8'hFF;

   typedef enum logic [1:0] {
      FUNC_BYTE     = 2'd0,
      FUNC_START    = 2'd1,
      FUNC_DEADLINE = 2'd2,
      FUNC_CLEAR    = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      STATUS_IDLE    = 3'd0,
      STATUS_GOOD    = 3'd1,
      STATUS_BAD     = 3'd2,
      STATUS_OVER    = 3'd3,
      STATUS_TIMEOUT = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_GOOD    = 3'd1,
      EV_BAD     = 3'd2,
      EV_OVER    = 3'd3,
      EV_TIMEOUT = 3'd4,
      EV_CLEAR   = 3'd5
   } ev_kind_type;

   typedef struct packed {
      ev_kind_type           kind;
      logic [VALUE_BITS-1:0] value;
   } event_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef struct packed {
      logic                  done;
      logic [VALUE_BITS-1:0] quotient;
   } div_result_type;

endpackage

`default_nettype wire

[src/co2sfr_front.sv]
// Front end: holds the limit register, assembles reply frames and classifies
// each request into one event for the back end. Depends on co2sfr_pkg.
`default_nettype none

module co2sfr_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic [1:0]            req_func,
   input  wire logic [7:0]            req_rx_byte,
   input  wire logic                  csr_valid,
   input  wire logic [15:0]           csr_data,
   input  wire co2sfr_pkg::fifo_status_type fifo_status,
   output logic                       push,
   output co2sfr_pkg::event_type      push_event
);
   import co2sfr_pkg::*;

   logic                  frame_open_ff, frame_open_in;
   logic [3:0]            bytes_taken_ff, bytes_taken_in;
   logic [7:0]            reply_code_ff, reply_code_in;
   logic [7:0]            value_high_ff, value_high_in;
   logic [7:0]            value_low_ff, value_low_in;
   logic [7:0]            byte_sum_ff, byte_sum_in;
   logic [VALUE_BITS-1:0] max_ppm_ff, max_ppm_in;
   logic [VALUE_BITS-1:0] frame_value;
   logic [7:0]            expect_check;
   func_type              func;

   assign push         = req_valid && !fifo_status.full;
   assign func         = func_type'(req_func);
   assign frame_value  = {value_high_ff, value_low_ff};
   assign expect_check = 8'(8'd0 - byte_sum_ff);
   assign max_ppm_in   = csr_valid ? csr_data : max_ppm_ff;

   always_comb begin
      frame_open_in    = frame_open_ff;
      bytes_taken_in   = bytes_taken_ff;
      reply_code_in    = reply_code_ff;
      value_high_in    = value_high_ff;
      value_low_in     = value_low_ff;
      byte_sum_in      = byte_sum_ff;
      push_event.kind  = EV_NONE;
      push_event.value = frame_value;
      unique case (func)
         FUNC_BYTE: begin
            if (frame_open_ff) begin
               if (bytes_taken_ff == 4'd0) begin
                  if (req_rx_byte == START_BYTE) begin
                     bytes_taken_in = 4'd1;
                     byte_sum_in    = 8'd0;
                  end
               end else if (bytes_taken_ff == CHECK_POS) begin
                  frame_open_in  = 1'b0;
                  bytes_taken_in = 4'd0;
                  if (reply_code_ff != REPLY_CODE || req_rx_byte != expect_check) begin
                     push_event.kind = EV_BAD;
                  end else if (frame_value > max_ppm_ff) begin
                     push_event.kind = EV_OVER;
                  end else begin
                     push_event.kind = EV_GOOD;
                  end
               end else begin
                  if (bytes_taken_ff == 4'd1) begin
                     reply_code_in = req_rx_byte;
                  end
                  if (bytes_taken_ff == 4'd2) begin
                     value_high_in = req_rx_byte;
                  end
                  if (bytes_taken_ff == 4'd3) begin
                     value_low_in = req_rx_byte;
                  end
                  byte_sum_in    = 8'(byte_sum_ff + req_rx_byte);
                  bytes_taken_in = 4'(bytes_taken_ff + 4'd1);
               end
            end
         end
         FUNC_START: begin
            frame_open_in  = 1'b1;
            bytes_taken_in = 4'd0;
            byte_sum_in    = 8'd0;
         end
         FUNC_DEADLINE: begin
            if (frame_open_ff) begin
               frame_open_in   = 1'b0;
               bytes_taken_in  = 4'd0;
               push_event.kind = EV_TIMEOUT;
            end
         end
         FUNC_CLEAR: begin
            push_event.kind = EV_CLEAR;
         end
         default: begin
            push_event.kind = EV_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff  <= 1'b0;
         bytes_taken_ff <= 4'd0;
         reply_code_ff  <= 8'd0;
         value_high_ff  <= 8'd0;
         value_low_ff   <= 8'd0;
         byte_sum_ff    <= 8'd0;
         max_ppm_ff     <= MAX_PPM_RESET;
      end else begin
         max_ppm_ff <= max_ppm_in;
         if (push) begin
            frame_open_ff  <= frame_open_in;
            bytes_taken_ff <= bytes_taken_in;
            reply_code_ff  <= reply_code_in;
            value_high_ff  <= value_high_in;
            value_low_ff   <= value_low_in;
            byte_sum_ff    <= byte_sum_in;
         end
      end
   end

endmodule

`default_nettype wire

[src/co2sfr_fifo.sv]
// Short event queue between the front end and the back end.
// Depends on co2sfr_pkg for the event type and the queue depth.
`default_nettype none

module co2sfr_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire co2sfr_pkg::event_type  push_event,
   input  wire logic                   pop,
   output co2sfr_pkg::event_type       head_event,
   output co2sfr_pkg::fifo_status_type status
);
   import co2sfr_pkg::*;

   event_type                entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;

   assign status.full  = (count_ff == FIFO_CNT_BITS'(FIFO_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_event   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? FIFO_PTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? FIFO_PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = FIFO_CNT_BITS'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = FIFO_CNT_BITS'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_event;
      end
   end

endmodule

`default_nettype wire

[src/co2sfr_div.sv]
// Restoring divider, one quotient bit per cycle, for the window mean.
// Depends on co2sfr_pkg for the operand widths.
`default_nettype none

module co2sfr_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [co2sfr_pkg::TOTAL_BITS-1:0] dividend,
   input  wire logic [co2sfr_pkg::COUNT_BITS-1:0] divisor,
   output co2sfr_pkg::div_result_type             result
);
   import co2sfr_pkg::*;

   logic [DIV_CNT_BITS-1:0] iter_ff, iter_in;
   logic                    done_ff, done_in;
   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [TOTAL_BITS-1:0]   quo_ff, quo_in;
   logic [COUNT_BITS-1:0]   div_ff, div_in;
   logic [COUNT_BITS:0]     rem_shift;
   logic                    fits;

   assign rem_shift       = {rem_ff, quo_ff[TOTAL_BITS-1]};
   assign fits            = (rem_shift >= {1'b0, div_ff});
   assign result.done     = done_ff;
   assign result.quotient = quo_ff[VALUE_BITS-1:0];

   always_comb begin
      iter_in = iter_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         iter_in = DIV_CNT_BITS'(TOTAL_BITS);
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (iter_ff != '0) begin
         iter_in = DIV_CNT_BITS'(iter_ff - 1'b1);
         done_in = (iter_ff == DIV_CNT_BITS'(1));
         rem_in  = fits ? COUNT_BITS'(rem_shift - {1'b0, div_ff}) : rem_shift[COUNT_BITS-1:0];
         quo_in  = {quo_ff[TOTAL_BITS-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         iter_ff <= iter_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

endmodule

`default_nettype wire

[src/co2sfr_back.sv]
// Back end: applies queued events to the reading and window state, runs the
// mean division and holds the result register. Depends on co2sfr_pkg,
// co2sfr_div and the assertion macro header.
`default_nettype none
`include "co2_sensor_frame_receiver_core_defines.svh"

module co2sfr_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire co2sfr_pkg::event_type      head_event,
   input  wire co2sfr_pkg::fifo_status_type fifo_status,
   output logic                            pop,
   input  wire logic                       rsp_stall,
   output logic                            rsp_valid,
   output logic [2:0]                      rsp_status,
   output logic [15:0]                     rsp_reading_ppm,
   output logic [7:0]                      rsp_error_run,
   output logic                            rsp_has_reading,
   output logic [15:0]                     rsp_window_peak,
   output logic [15:0]                     rsp_window_mean,
   output logic [23:0]                     rsp_window_count
);
   import co2sfr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type             state_ff, state_in;
   status_type            status_ff, status_in;
   logic [VALUE_BITS-1:0] last_value_ff, last_value_in;
   logic [7:0]            fail_count_ff, fail_count_in;
   logic                  seen_good_ff, seen_good_in;
   logic [VALUE_BITS-1:0] peak_value_ff, peak_value_in;
   logic [TOTAL_BITS-1:0] value_total_ff, value_total_in;
   logic [COUNT_BITS-1:0] sample_total_ff, sample_total_in;
   logic [VALUE_BITS-1:0] mean_ff, mean_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_status_ff, rsp_status_in;
   logic [15:0]           rsp_reading_ff, rsp_reading_in;
   logic [7:0]            rsp_error_ff, rsp_error_in;
   logic                  rsp_has_ff, rsp_has_in;
   logic [15:0]           rsp_peak_ff, rsp_peak_in;
   logic [15:0]           rsp_mean_ff, rsp_mean_in;
   logic [23:0]           rsp_count_ff, rsp_count_in;
   logic [CNT_EXT_BITS-1:0] count_ext;
   logic                  div_start;
   div_result_type        div_result;

   co2sfr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (value_total_ff),
      .divisor  (sample_total_ff),
      .result   (div_result)
   );

   assign count_ext        = CNT_EXT_BITS'(sample_total_ff);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_reading_ppm  = rsp_reading_ff;
   assign rsp_error_run    = rsp_error_ff;
   assign rsp_has_reading  = rsp_has_ff;
   assign rsp_window_peak  = rsp_peak_ff;
   assign rsp_window_mean  = rsp_mean_ff;
   assign rsp_window_count = rsp_count_ff;

   always_comb begin
      state_in        = state_ff;
      status_in       = status_ff;
      last_value_in   = last_value_ff;
      fail_count_in   = fail_count_ff;
      seen_good_in    = seen_good_ff;
      peak_value_in   = peak_value_ff;
      value_total_in  = value_total_ff;
      sample_total_in = sample_total_ff;
      mean_in         = mean_ff;
      pop             = 1'b0;
      div_start       = 1'b0;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_reading_in  = rsp_reading_ff;
      rsp_error_in    = rsp_error_ff;
      rsp_has_in      = rsp_has_ff;
      rsp_peak_in     = rsp_peak_ff;
      rsp_mean_in     = rsp_mean_ff;
      rsp_count_in    = rsp_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!fifo_status.empty) begin
               pop      = 1'b1;
               state_in = ST_START;
               unique case (head_event.kind)
                  EV_GOOD: begin
                     status_in     = STATUS_GOOD;
                     last_value_in = head_event.value;
                     fail_count_in = 8'd0;
                     seen_good_in  = 1'b1;
                     if (sample_total_ff != COUNT_MAX) begin
                        value_total_in  = TOTAL_BITS'(value_total_ff
                                                      + TOTAL_BITS'(head_event.value));
                        sample_total_in = COUNT_BITS'(sample_total_ff + 1'b1);
                     end
                     if (head_event.value > peak_value_ff) begin
                        peak_value_in = head_event.value;
                     end
                  end
                  EV_BAD, EV_OVER, EV_TIMEOUT: begin
                     if (head_event.kind == EV_BAD) begin
                        status_in = STATUS_BAD;
                     end else if (head_event.kind == EV_OVER) begin
                        status_in = STATUS_OVER;
                     end else begin
                        status_in = STATUS_TIMEOUT;
                     end
                     if (fail_count_ff != FAIL_MAX) begin
                        fail_count_in = 8'(fail_count_ff + 8'd1);
                     end
                  end
                  EV_CLEAR: begin
                     status_in       = STATUS_IDLE;
                     value_total_in  = '0;
                     sample_total_in = '0;
                     peak_value_in   = '0;
                  end
                  default: begin
                     status_in = STATUS_IDLE;
                  end
               endcase
            end
         end
         ST_START: begin
            if (sample_total_ff == '0) begin
               mean_in  = '0;
               state_in = ST_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_result.done) begin
               mean_in  = div_result.quotient;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_reading_in = last_value_ff;
               rsp_error_in   = fail_count_ff;
               rsp_has_in     = seen_good_ff;
               rsp_peak_in    = peak_value_ff;
               rsp_mean_in    = mean_ff;
               rsp_count_in   = (count_ext > CNT_EXT_BITS'(OUT_COUNT_MAX))
                                ? OUT_COUNT_MAX : count_ext[OUT_COUNT_BITS-1:0];
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         last_value_ff   <= '0;
         fail_count_ff   <= 8'd0;
         seen_good_ff    <= 1'b0;
         peak_value_ff   <= '0;
         value_total_ff  <= '0;
         sample_total_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         last_value_ff   <= last_value_in;
         fail_count_ff   <= fail_count_in;
         seen_good_ff    <= seen_good_in;
         peak_value_ff   <= peak_value_in;
         value_total_ff  <= value_total_in;
         sample_total_ff <= sample_total_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      status_ff      <= status_in;
      mean_ff        <= mean_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_reading_ff <= rsp_reading_in;
      rsp_error_ff   <= rsp_error_in;
      rsp_has_ff     <= rsp_has_in;
      rsp_peak_ff    <= rsp_peak_in;
      rsp_mean_ff    <= rsp_mean_in;
      rsp_count_ff   <= rsp_count_in;
   end

   `CO2SFR_ASSERT(a_done_in_div, clock, reset, !div_result.done || state_ff == ST_DIV, "divider finished outside the divide state")
   `CO2SFR_ASSERT_NEXT(a_window_hold, clock, reset, !pop, $stable(sample_total_ff), "window count changed without a queued event")
   `CO2SFR_ASSERT_NEXT(a_good_clears, clock, reset, pop && head_event.kind == EV_GOOD, fail_count_ff == 8'd0, "good reading left the error run set")

endmodule

`default_nettype wire

[src/co2_sensor_frame_receiver_core.sv]
// Top level of the gas sensor reply frame receiver.
// Depends on co2sfr_pkg, co2sfr_front, co2sfr_fifo and co2sfr_back.
//
//   Channel  Prefix  Handshake       Moves
//   request  req_    valid / stall   func code and received byte
//   result   rsp_    valid / stall   status, reading and window statistics
//   config   csr_    valid / ready   max_ppm limit, always ready
//
// The front end takes a request whenever the two-entry queue has room.
// In the back end each result passes through the idle, start, divide and output states; the 40-step serial
// divider forms the window mean, and an empty window skips the divider.
// Reset is synchronous; it clears the control, reading and window state and sets the limit to 5000 ppm.
// A stalled result holds in the output register while the next item proceeds.
`default_nettype none

module co2_sensor_frame_receiver_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_reading_ppm,
   output logic [7:0]       rsp_error_run,
   output logic             rsp_has_reading,
   output logic [15:0]      rsp_window_peak,
   output logic [15:0]      rsp_window_mean,
   output logic [23:0]      rsp_window_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);
   import co2sfr_pkg::*;

   logic            push;
   logic            pop;
   event_type       push_event;
   event_type       head_event;
   fifo_status_type fifo_status;

   assign req_stall = fifo_status.full;
   assign csr_ready = 1'b1;

   co2sfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_func    (req_func),
      .req_rx_byte (req_rx_byte),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .fifo_status (fifo_status),
      .push        (push),
      .push_event  (push_event)
   );

   co2sfr_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .pop        (pop),
      .head_event (head_event),
      .status     (fifo_status)
   );

   co2sfr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_event       (head_event),
      .fifo_status      (fifo_status),
      .pop              (pop),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_reading_ppm  (rsp_reading_ppm),
      .rsp_error_run    (rsp_error_run),
      .rsp_has_reading  (rsp_has_reading),
      .rsp_window_peak  (rsp_window_peak),
      .rsp_window_mean  (rsp_window_mean),
      .rsp_window_count (rsp_window_count)
   );

endmodule

`default_nettype wire

[sim/co2_sensor_frame_receiver_check.sv]
// Checker for the gas sensor reply frame receiver: watches the request, result
// and register channels, predicts every result and compares it field by field.
// Depends on co2sfr_pkg for the code enums, widths and frame constants.
module co2_sensor_frame_receiver_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [15:0] rsp_reading_ppm,
   input  logic [7:0]  rsp_error_run,
   input  logic        rsp_has_reading,
   input  logic [15:0] rsp_window_peak,
   input  logic [15:0] rsp_window_mean,
   input  logic [23:0] rsp_window_count,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_data,
   output int          mismatches,
   output int          awaiting
);
   timeunit 1ns;
   timeprecision 1ps;

   import co2sfr_pkg::*;

   typedef struct packed {
      status_type                  status;
      logic [VALUE_BITS-1:0]       reading;
      logic [7:0]                  error_run;
      logic                        has_reading;
      logic [VALUE_BITS-1:0]       peak;
      logic [VALUE_BITS-1:0]       mean;
      logic [OUT_COUNT_BITS-1:0]   count;
   } report_type;

   report_type reports_due[$];
   int errors = 0;

   logic [VALUE_BITS-1:0] limit_ppm;
   logic                  frame_open;
   logic [3:0]            taken;
   logic [7:0]            code_seen;
   logic [7:0]            hi_byte;
   logic [7:0]            lo_byte;
   logic [7:0]            running_sum;
   logic [VALUE_BITS-1:0] last_ppm;
   logic [7:0]            fail_run;
   logic                  got_good;
   logic [VALUE_BITS-1:0] peak_ppm;
   logic [TOTAL_BITS-1:0] ppm_total;
   logic [COUNT_BITS-1:0] reading_count;

   initial begin
      mismatches = 0;
      awaiting = 0;
   end

   task automatic note_failed_frame();
      if (fail_run != FAIL_MAX) begin
         fail_run++;
      end
   endtask

   task automatic predict_report(input func_type func, input logic [7:0] rx,
                                 output report_type rep);
      status_type            status;
      logic [VALUE_BITS-1:0] value;
      logic [7:0]            check_due;
      status = STATUS_IDLE;
      case (func)
         FUNC_BYTE: begin
            if (frame_open) begin
               if (taken == 4'd0) begin
                  if (rx == START_BYTE) begin
                     taken = 4'd1;
                     running_sum = 8'd0;
                  end
               end else if (taken == CHECK_POS) begin
                  frame_open = 1'b0;
                  taken = 4'd0;
                  check_due = ~running_sum + 8'd1;
                  value = {hi_byte, lo_byte};
                  if (code_seen != REPLY_CODE || rx != check_due) begin
                     note_failed_frame();
                     status = STATUS_BAD;
                  end else if (value > limit_ppm) begin
                     note_failed_frame();
                     status = STATUS_OVER;
                  end else begin
                     last_ppm = value;
                     fail_run = 8'd0;
                     got_good = 1'b1;
                     if (reading_count != COUNT_MAX) begin
                        ppm_total = ppm_total + TOTAL_BITS'(value);
                        reading_count = reading_count + 1'b1;
                     end
                     if (value > peak_ppm) begin
                        peak_ppm = value;
                     end
                     status = STATUS_GOOD;
                  end
               end else begin
                  case (taken)
                     4'd1: code_seen = rx;
                     4'd2: hi_byte = rx;
                     4'd3: lo_byte = rx;
                     default: ;
                  endcase
                  running_sum = running_sum + rx;
                  taken = taken + 4'd1;
               end
            end
         end
         FUNC_START: begin
            frame_open = 1'b1;
            taken = 4'd0;
            running_sum = 8'd0;
         end
         FUNC_DEADLINE: begin
            if (frame_open) begin
               frame_open = 1'b0;
               taken = 4'd0;
               note_failed_frame();
               status = STATUS_TIMEOUT;
            end
         end
         default: begin
            ppm_total = '0;
            reading_count = '0;
            peak_ppm = '0;
         end
      endcase
      rep.status = status;
      rep.reading = last_ppm;
      rep.error_run = fail_run;
      rep.has_reading = got_good;
      rep.peak = peak_ppm;
      rep.mean = (reading_count == '0) ? '0
               : VALUE_BITS'(ppm_total / TOTAL_BITS'(reading_count));
      rep.count = (CNT_EXT_BITS'(reading_count) > CNT_EXT_BITS'(OUT_COUNT_MAX))
                ? OUT_COUNT_MAX : OUT_COUNT_BITS'(reading_count);
   endtask

   function automatic void check_field(string field, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : watch
      report_type seen;
      report_type due;
      if (reset) begin
         reports_due.delete();
         limit_ppm = MAX_PPM_RESET;
         frame_open = 1'b0;
         taken = 4'd0;
         code_seen = 8'd0;
         hi_byte = 8'd0;
         lo_byte = 8'd0;
         running_sum = 8'd0;
         last_ppm = '0;
         fail_run = 8'd0;
         got_good = 1'b0;
         peak_ppm = '0;
         ppm_total = '0;
         reading_count = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.status = status_type'(rsp_status);
            seen.reading = rsp_reading_ppm;
            seen.error_run = rsp_error_run;
            seen.has_reading = rsp_has_reading;
            seen.peak = rsp_window_peak;
            seen.mean = rsp_window_mean;
            seen.count = rsp_window_count;
            if (reports_due.size() == 0) begin
               $error("Result transaction arrived with no request outstanding.");
               errors++;
            end else begin
               due = reports_due.pop_front();
               check_field("status", 24'(due.status), 24'(seen.status));
               check_field("reading_ppm", 24'(due.reading), 24'(seen.reading));
               check_field("error_run", 24'(due.error_run), 24'(seen.error_run));
               check_field("has_reading", 24'(due.has_reading), 24'(seen.has_reading));
               check_field("window_peak", 24'(due.peak), 24'(seen.peak));
               check_field("window_mean", 24'(due.mean), 24'(seen.mean));
               check_field("window_count", 24'(due.count), 24'(seen.count));
            end
         end
         if (csr_valid && csr_ready) begin
            limit_ppm = csr_data;
         end
         if (req_valid && !req_stall) begin
            predict_report(func_type'(req_func), req_rx_byte, due);
            reports_due.push_back(due);
         end
      end
      awaiting <= reports_due.size();
      mismatches <= errors;
   end

endmodule

[sim/co2_sensor_frame_receiver_core_test.sv]
// Top of the gas sensor frame receiver testbench: clock, reset, stimulus and verdict.
// Depends on co2sfr_pkg, the block co2_sensor_frame_receiver_core and the
// checker co2_sensor_frame_receiver_check, which predicts and compares results.
module co2_sensor_frame_receiver_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import co2sfr_pkg::*;

   localparam int CYCLE_LIMIT    = 1_500_000;
   localparam int PHASE_ITEMS    = 120;
   localparam int FAILURE_STREAK = 270;
   localparam int SETTLE_CYCLES  = 64;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_CODE,
      FRAME_BAD_SUM,
      FRAME_OVER,
      FRAME_TIMEOUT,
      FRAME_RESTART
   } frame_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_BYTE;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_reading_ppm;
   logic [7:0]  rsp_error_run;
   logic        rsp_has_reading;
   logic [15:0] rsp_window_peak;
   logic [15:0] rsp_window_mean;
   logic [23:0] rsp_window_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = 16'd0;

   int mismatches;
   int awaiting;
   int cycles = 0;
   int stall_mode = 0;
   int stall_left = 0;
   int burst_left = 0;
   int sent = 0;
   logic [15:0] limit_now = MAX_PPM_RESET;

   co2_sensor_frame_receiver_core u_top (.*);

   co2_sensor_frame_receiver_check u_check (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(50, 400);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ((stall_left % 32) >= 16);
      endcase
   end

   task automatic send_item(input func_type func, input logic [7:0] rx);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_rx_byte <= rx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      sent++;
   endtask

   task automatic send_frame(input frame_kind_type kind);
      logic [7:0]  body [1:7];
      logic [7:0]  check;
      logic [15:0] value;
      int          cut;
      value = 16'($urandom);
      if (kind == FRAME_OVER && limit_now == 16'hFFFF) begin
         kind = FRAME_BAD_SUM;
      end
      if (kind == FRAME_GOOD) begin
         case ($urandom_range(0, 3))
            0: value = 16'd0;
            1: value = limit_now;
            default: value = 16'($urandom_range(0, limit_now));
         endcase
      end else if (kind == FRAME_OVER) begin
         case ($urandom_range(0, 2))
            0: value = limit_now + 16'd1;
            1: value = 16'hFFFF;
            default: value = 16'($urandom_range(limit_now + 1, 16'hFFFF));
         endcase
      end
      body[1] = REPLY_CODE;
      if (kind == FRAME_BAD_CODE) begin
         body[1] = REPLY_CODE ^ 8'($urandom_range(1, 255));
      end
      body[2] = value[15:8];
      body[3] = value[7:0];
      for (int i = 4; i <= 7; i++) begin
         body[i] = 8'($urandom);
      end
      check = 8'd0;
      for (int i = 1; i <= 7; i++) begin
         check = check + body[i];
      end
      check = ~check + 8'd1;
      if (kind == FRAME_BAD_SUM) begin
         check = check ^ 8'($urandom_range(1, 255));
      end
      send_item(FUNC_START, 8'($urandom));
      repeat ($urandom_range(0, 2)) send_item(FUNC_BYTE, 8'($urandom_range(0, 254)));
      send_item(FUNC_BYTE, START_BYTE);
      if (kind == FRAME_TIMEOUT || kind == FRAME_RESTART) begin
         cut = $urandom_range(0, 7);
         for (int i = 1; i <= cut; i++) begin
            send_item(FUNC_BYTE, body[i]);
         end
         if (kind == FRAME_TIMEOUT) begin
            send_item(FUNC_DEADLINE, 8'($urandom));
         end
      end else begin
         for (int i = 1; i <= 7; i++) begin
            send_item(FUNC_BYTE, body[i]);
         end
         send_item(FUNC_BYTE, check);
      end
   endtask

   task automatic send_random_unit();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         send_frame(FRAME_GOOD);
      end else if (pick < 64) begin
         send_frame(FRAME_BAD_CODE);
      end else if (pick < 72) begin
         send_frame(FRAME_BAD_SUM);
      end else if (pick < 80) begin
         send_frame(FRAME_OVER);
      end else if (pick < 86) begin
         send_frame(FRAME_TIMEOUT);
      end else if (pick < 91) begin
         send_frame(FRAME_RESTART);
      end else if (pick < 95) begin
         send_item(FUNC_CLEAR, 8'($urandom));
      end else begin
         repeat ($urandom_range(1, 4)) begin
            send_item(func_type'($urandom_range(0, 3)), 8'($urandom));
         end
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] limit);
      settle();
      csr_valid <= 1'b1;
      csr_data <= limit;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      limit_now = limit;
   endtask

   initial begin
      logic [15:0] settings [6];
      int          phase_start;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: ignored items, a good frame at the default limit, a
      // restarted frame, timeouts and a window clear with a frame open.
      send_item(FUNC_BYTE, 8'hFF);
      send_item(FUNC_DEADLINE, 8'h00);
      send_item(FUNC_CLEAR, 8'hFF);
      send_item(FUNC_START, 8'h00);
      send_item(FUNC_BYTE, 8'h00);
      send_item(FUNC_BYTE, START_BYTE);
      send_item(FUNC_BYTE, REPLY_CODE);
      send_item(FUNC_BYTE, 8'h13);
      send_item(FUNC_BYTE, 8'h88);
      repeat (4) send_item(FUNC_BYTE, 8'h00);
      send_item(FUNC_BYTE, 8'hDF);
      send_item(FUNC_START, 8'h00);
      send_item(FUNC_BYTE, START_BYTE);
      send_item(FUNC_BYTE, REPLY_CODE);
      send_item(FUNC_START, 8'hFF);
      send_item(FUNC_BYTE, START_BYTE);
      send_item(FUNC_DEADLINE, 8'h00);
      send_item(FUNC_START, 8'h00);
      send_item(FUNC_CLEAR, 8'h00);
      send_item(FUNC_DEADLINE, 8'hFF);

      // A long run of failed frames drives the error run into saturation.
      write_limit(16'hFFFF);
      repeat (FAILURE_STREAK) begin
         if ($urandom_range(0, 15) == 0) begin
            send_frame(FRAME_BAD_CODE);
         end else begin
            send_item(FUNC_START, 8'($urandom));
            send_item(FUNC_DEADLINE, 8'($urandom));
         end
      end
      send_frame(FRAME_GOOD);

      settings[0] = 16'd0;
      settings[1] = 16'hFFFF;
      settings[2] = 16'($urandom_range(2, 65534));
      settings[3] = 16'd1;
      settings[4] = MAX_PPM_RESET;
      settings[5] = 16'($urandom_range(2, 65534));
      foreach (settings[p]) begin
         write_limit(settings[p]);
         phase_start = sent;
         while (sent - phase_start < PHASE_ITEMS) begin
            send_random_unit();
         end
      end

      settle();
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
